// ----- hw/rtl/mssd_pkg.sv -----
// Package for the multiplexed seven-segment driver.
// Field widths, command codes, controller/datapath structs and the segment table.
// No dependencies.
`default_nettype none

package mssd_pkg;

  localparam int VALUE_W        = 27;
  localparam int POS_W          = 3;
  localparam int SEG_W          = 7;
  localparam int DIGIT_W        = 4;
  localparam int CNT_W          = $clog2(VALUE_W);
  localparam int NUM_DIGITS_DEF = 8;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_CONV
  } state_t;

  typedef struct packed {
    logic load_start;
    logic shift;
    logic capture;
  } dp_cmd_t;

  typedef struct packed {
    logic last_bit;
    logic out_hold;
  } dp_status_t;

  // Common-cathode code, bit 0 is segment a. Codes above nine show blank.
  function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/multiplexed_seven_segment_driver.sv -----
// Multiplexed seven-segment driver: load requests fill the digit store, tick requests
// give the scan position and its segment code. A tick's result is registered and valid
// the cycle after acceptance; throughput is one tick per cycle while no result is held
// back by out_stall and no load is converting. A load holds the input stalled while the
// shift-add-3 loop converts it, one value bit per step. Synchronous reset clears all
// digits to zero, the scan position to zero and drops any pending result.
`default_nettype none

module multiplexed_seven_segment_driver #(
  parameter int NUM_DIGITS = mssd_pkg::NUM_DIGITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        cmd,
  input  logic [mssd_pkg::VALUE_W-1:0] value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mssd_pkg::POS_W-1:0]  digit_position,
  output logic [mssd_pkg::SEG_W-1:0]  segments
);
  import mssd_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  mssd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .dp_cmd    (dp_cmd),
    .dp_status (dp_status)
  );

  mssd_dp #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .value          (value),
    .dp_cmd         (dp_cmd),
    .dp_status      (dp_status),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .digit_position (digit_position),
    .segments       (segments)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/mssd_ctrl.sv -----
// Controller for the seven-segment driver: accepts requests and sequences a load.
// Depends on mssd_pkg.
`default_nettype none

module mssd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 cmd,
  output mssd_pkg::dp_cmd_t    dp_cmd,
  input  mssd_pkg::dp_status_t dp_status
);
  import mssd_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && cmd == CMD_LOAD) begin
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        if (dp_status.last_bit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall          = 1'b1;
    dp_cmd.load_start = 1'b0;
    dp_cmd.shift      = 1'b0;
    dp_cmd.capture    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // A waiting result blocks new requests until it drains.
        in_stall          = dp_status.out_hold;
        dp_cmd.load_start = in_valid && !dp_status.out_hold && cmd == CMD_LOAD;
        dp_cmd.capture    = in_valid && !dp_status.out_hold && cmd == CMD_TICK;
      end
      ST_CONV: begin
        dp_cmd.shift = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  a_load_starts_conv: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && accept && cmd == CMD_LOAD) |=> state == ST_CONV)
    else $error("load request did not start a conversion");

  a_conv_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV && dp_status.last_bit) |=> state == ST_IDLE)
    else $error("conversion did not end after its last bit");

  a_conv_stalls: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV) |-> in_stall)
    else $error("request accepted during a conversion");

endmodule

`default_nettype wire

// ----- hw/rtl/mssd_dp.sv -----
// Datapath for the seven-segment driver: shift-add-3 binary to BCD conversion,
// digit store, scan position and the registered result. Depends on mssd_pkg.
`default_nettype none

module mssd_dp #(
  parameter int NUM_DIGITS = mssd_pkg::NUM_DIGITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [mssd_pkg::VALUE_W-1:0] value,
  input  mssd_pkg::dp_cmd_t           dp_cmd,
  output mssd_pkg::dp_status_t        dp_status,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mssd_pkg::POS_W-1:0]  digit_position,
  output logic [mssd_pkg::SEG_W-1:0]  segments
);
  import mssd_pkg::*;

  localparam int IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  logic [DIGIT_W-1:0] digits      [NUM_DIGITS];
  logic [DIGIT_W-1:0] digits_next [NUM_DIGITS];
  logic [DIGIT_W-1:0] adj         [NUM_DIGITS];
  logic [VALUE_W-1:0] sr;
  logic [CNT_W-1:0]   cnt;
  logic [POS_W-1:0]   scan_index;

  // Each digit at five or more gets three added before the shift; a carry out
  // of the top digit is dropped, which keeps only the lowest digits.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i] = (digits[i] >= DIGIT_W'(5)) ? digits[i] + DIGIT_W'(3) : digits[i];
    end
    digits_next[0] = {adj[0][DIGIT_W-2:0], sr[VALUE_W-1]};
    for (int i = 1; i < NUM_DIGITS; i++) begin
      digits_next[i] = {adj[i][DIGIT_W-2:0], adj[i-1][DIGIT_W-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        digits[i] <= '0;
      end
      cnt <= '0;
    end else if (dp_cmd.load_start) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        digits[i] <= '0;
      end
      cnt <= '0;
    end else if (dp_cmd.shift) begin
      digits <= digits_next;
      cnt    <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load_start) begin
      sr <= value;
    end else if (dp_cmd.shift) begin
      sr <= {sr[VALUE_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_index <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (dp_cmd.capture) begin
        out_valid <= 1'b1;
        if (scan_index == POS_W'(NUM_DIGITS - 1)) begin
          scan_index <= '0;
        end else begin
          scan_index <= scan_index + POS_W'(1);
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      digit_position <= scan_index;
      segments       <= seg_of(digits[scan_index[IDX_W-1:0]]);
    end
  end

  assign dp_status.last_bit = (cnt == CNT_W'(VALUE_W - 1));
  assign dp_status.out_hold = out_valid && out_stall;

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    32'(scan_index) < NUM_DIGITS)
    else $error("scan position beyond the last digit");

  a_cnt_in_range: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.shift |-> 32'(cnt) < VALUE_W)
    else $error("conversion ran past the last input bit");

  a_capture_shows: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.capture |=> out_valid)
    else $error("scan tick gave no result");

endmodule

`default_nettype wire

// ----- test/tb_multiplexed_seven_segment_driver.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the multiplexed seven-segment driver.
// Holds a scoreboard class that predicts each scan result from loads and ticks.
// Depends on mssd_pkg and multiplexed_seven_segment_driver.

class scan_scoreboard;
  localparam int NDIG = mssd_pkg::NUM_DIGITS_DEF;

  typedef struct packed {
    logic [mssd_pkg::POS_W-1:0] pos;
    logic [mssd_pkg::SEG_W-1:0] seg;
  } glyph_t;

  logic [mssd_pkg::DIGIT_W-1:0] digits [8];
  logic [mssd_pkg::POS_W-1:0]   scan_pos;
  logic [mssd_pkg::SEG_W-1:0]   glyph_rom [10];
  glyph_t                       pending_glyphs [$];
  int                           fails;

  function new();
    glyph_rom = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F};
    foreach (digits[k]) digits[k] = '0;
    scan_pos = '0;
    fails = 0;
  endfunction

  // Called once per accepted request, in acceptance order.
  function void note_request(logic c, logic [mssd_pkg::VALUE_W-1:0] v);
    int unsigned rest;
    int          k;
    glyph_t      g;
    if (c == mssd_pkg::CMD_LOAD) begin
      rest = 32'(v);
      for (k = 0; k < 8; k++) begin
        if (k < NDIG) begin
          digits[k] = mssd_pkg::DIGIT_W'(rest % 10);
          rest = rest / 10;
        end else begin
          digits[k] = '0;
        end
      end
    end else begin
      g.pos = scan_pos;
      g.seg = (digits[scan_pos] > 9) ? '0 : glyph_rom[digits[scan_pos]];
      pending_glyphs.push_back(g);
      if (int'(scan_pos) + 1 >= NDIG) scan_pos = '0;
      else scan_pos = scan_pos + 3'd1;
    end
  endfunction

  function void check_glyph(logic [mssd_pkg::POS_W-1:0] pos, logic [mssd_pkg::SEG_W-1:0] seg);
    glyph_t want;
    if (pending_glyphs.size() == 0) begin
      fails++;
      if (fails <= 10)
        $display("scan result with no tick pending: position %0d segments %h", pos, seg);
      return;
    end
    want = pending_glyphs.pop_front();
    if (pos !== want.pos || seg !== want.seg) begin
      fails++;
      if (fails <= 10)
        $display("scan result check failed: position exp %0d got %0d, segments exp %h got %h",
                 want.pos, pos, want.seg, seg);
    end
  endfunction

  function int pending();
    return pending_glyphs.size();
  endfunction

  function void close();
    if (pending_glyphs.size() > 0) begin
      $display("%0d scan results never arrived", pending_glyphs.size());
      fails += pending_glyphs.size();
    end
  endfunction
endclass

module tb_multiplexed_seven_segment_driver;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 1630;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         in_valid;
  logic                         in_stall;
  logic                         cmd;
  logic [mssd_pkg::VALUE_W-1:0] value;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [mssd_pkg::POS_W-1:0]   digit_position;
  logic [mssd_pkg::SEG_W-1:0]   segments;

  scan_scoreboard sb;
  bit             quiet;
  int             stall_left;
  int             idle_cycles;

  multiplexed_seven_segment_driver i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .value          (value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .digit_position (digit_position),
    .segments       (segments)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones; none at all during quiet stretches.
  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [mssd_pkg::VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return mssd_pkg::VALUE_W'($urandom);
    if (r < 7) return mssd_pkg::VALUE_W'($urandom_range(0, 99999999));
    if (r == 7) return mssd_pkg::VALUE_W'($urandom_range(0, 999));
    if (r == 8) return mssd_pkg::VALUE_W'($urandom_range(0, 9));
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return mssd_pkg::VALUE_W'(99999999);
      2:       return mssd_pkg::VALUE_W'(100000000);
      default: return '1;
    endcase
  endfunction

  task automatic send_request(input logic c, input logic [mssd_pkg::VALUE_W-1:0] v);
    in_valid <= 1'b1;
    cmd      <= c;
    value    <= v;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_request(c, v);
  endtask

  task automatic hold_off(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_load(input logic [mssd_pkg::VALUE_W-1:0] v);
    send_request(mssd_pkg::CMD_LOAD, v);
    hold_off(gap_len());
  endtask

  // The value field is don't-care on a tick, so it carries random bits.
  task automatic send_ticks(input int n);
    repeat (n) begin
      send_request(mssd_pkg::CMD_TICK, mssd_pkg::VALUE_W'($urandom));
      hold_off(gap_len());
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Receiver side: random stall bursts.
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 3) == 0) stall_left = gap_len();
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_glyph(digit_position, segments);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    sb = new();
    quiet = 1'b0;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    cmd      <= mssd_pkg::CMD_LOAD;
    value    <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part: reset contents, extremes, an oversized value, zero and short numbers.
    send_ticks(2);
    send_load(mssd_pkg::VALUE_W'(99999999));
    send_ticks(3);
    send_load('1);
    send_ticks(3);
    send_load('0);
    send_ticks(2);
    send_load(mssd_pkg::VALUE_W'(56789012));
    send_ticks(6);
    send_load(mssd_pkg::VALUE_W'(1));
    send_ticks(2);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = ((i / 120) % 5 == 4);
      if (i == RANDOM_ITEMS / 2) wait_drained();
      if ($urandom_range(0, 99) < 25) send_load(pick_value());
      else send_ticks(1);
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.close();
    if (sb.fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
